[design/rtgfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtgfd_pkg: shared types and constants
// Register codes, payload structs and sizing for the gray converter.
// ----------------------------------------------------------------------------
package rtgfd_pkg;

    localparam int C_MAX_WIDTH  = 4096;
    localparam int C_MAX_HEIGHT = 4096;
    localparam int C_POS_W      = 12;
    localparam int C_COEF_W     = 18;
    localparam int C_CFG_DATA_W = 18;
    localparam int C_Q_DEPTH    = 4;

    // BT.601 luma weights, Q14
    localparam logic signed [C_COEF_W-1:0] C_LUMA_B = 18'sd1868;
    localparam logic signed [C_COEF_W-1:0] C_LUMA_G = 18'sd9617;
    localparam logic signed [C_COEF_W-1:0] C_LUMA_R = 18'sd4899;

    typedef enum logic [2:0] {
        REG_CUSTOM_GRAY = 3'd0,
        REG_COEF_RED    = 3'd1,
        REG_COEF_GREEN  = 3'd2,
        REG_COEF_BLUE   = 3'd3,
        REG_FLIP_MODE   = 3'd4,
        REG_FRAME_W     = 3'd5,
        REG_FRAME_H     = 3'd6,
        REG_FRAME_DIV   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic                       custom_gray_enable;
        logic signed [C_COEF_W-1:0] coef_red;
        logic signed [C_COEF_W-1:0] coef_green;
        logic signed [C_COEF_W-1:0] coef_blue;
        logic [1:0]                 flip_mode;
        logic [12:0]                frame_width;
        logic [12:0]                frame_height;
        logic [7:0]                 frame_divider;
    } t_cfg;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix_in;

    typedef struct packed {
        logic [15:0]        gray_value;
        logic [C_POS_W-1:0] dest_column;
        logic [C_POS_W-1:0] dest_row;
        logic               frame_end;
    } t_pix_out;

    // One queued job: pixel plus its resolved destination
    typedef struct packed {
        t_pix_in            pix;
        logic [C_POS_W-1:0] dest_column;
        logic [C_POS_W-1:0] dest_row;
        logic               frame_end;
    } t_job;

endpackage
`default_nettype wire

[design/rtgfd_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtgfd_regs: configuration register bank
// Holds mode, coefficients, flip, frame size and divider.
// ----------------------------------------------------------------------------
module rtgfd_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [2:0]                          i_cfg_idx,
    input  wire logic [rtgfd_pkg::C_CFG_DATA_W-1:0]  i_cfg_data,
    output rtgfd_pkg::t_cfg                          o_cfg
);
    import rtgfd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx = t_reg_idx'(i_cfg_idx);
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.custom_gray_enable <= 1'b0;
            r_cfg.coef_red           <= 18'sd256;
            r_cfg.coef_green         <= 18'sd256;
            r_cfg.coef_blue          <= 18'sd256;
            r_cfg.flip_mode          <= 2'd0;
            r_cfg.frame_width        <= 13'd640;
            r_cfg.frame_height       <= 13'd480;
            r_cfg.frame_divider      <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (w_idx)
                REG_CUSTOM_GRAY: r_cfg.custom_gray_enable <= i_cfg_data[0];
                REG_COEF_RED:    r_cfg.coef_red           <= $signed(i_cfg_data[17:0]);
                REG_COEF_GREEN:  r_cfg.coef_green         <= $signed(i_cfg_data[17:0]);
                REG_COEF_BLUE:   r_cfg.coef_blue          <= $signed(i_cfg_data[17:0]);
                REG_FLIP_MODE:   r_cfg.flip_mode          <= i_cfg_data[1:0];
                REG_FRAME_W:     r_cfg.frame_width        <= i_cfg_data[12:0];
                REG_FRAME_H:     r_cfg.frame_height       <= i_cfg_data[12:0];
                REG_FRAME_DIV:   r_cfg.frame_divider      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[design/rtgfd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtgfd_front: raster position tracking and frame decimation
// Counts columns, rows and frames, applies flips and drops skipped frames.
// ----------------------------------------------------------------------------
module rtgfd_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rtgfd_pkg::t_cfg    i_cfg,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire rtgfd_pkg::t_pix_in i_pix,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output rtgfd_pkg::t_job         o_job
);
    import rtgfd_pkg::*;

    logic [C_POS_W-1:0] r_col, n_col;
    logic [C_POS_W-1:0] r_row, n_row;
    logic [7:0]         r_phase, n_phase;

    logic [C_POS_W-1:0] w_wm1, w_hm1;
    logic [C_POS_W-1:0] w_dcol, w_drow;
    logic               w_accept, w_emit, w_row_last, w_frame_last;

    // Clamp size to 1..MAX and take the last index
    assign w_wm1 = (i_cfg.frame_width == 13'd0) ? '0 :
                   (i_cfg.frame_width > 13'(C_MAX_WIDTH)) ? C_POS_W'(C_MAX_WIDTH - 1) :
                   C_POS_W'(i_cfg.frame_width - 13'd1);
    assign w_hm1 = (i_cfg.frame_height == 13'd0) ? '0 :
                   (i_cfg.frame_height > 13'(C_MAX_HEIGHT)) ? C_POS_W'(C_MAX_HEIGHT - 1) :
                   C_POS_W'(i_cfg.frame_height - 13'd1);

    assign o_stall      = i_q_full;
    assign w_accept     = i_valid && !i_q_full;
    assign w_emit       = ({1'b0, r_phase} + 9'd1) >= {1'b0, i_cfg.frame_divider};
    assign w_row_last   = r_col >= w_wm1;
    assign w_frame_last = w_row_last && (r_row >= w_hm1);

    // Past the last index a mirrored position pins to zero
    assign w_dcol = !i_cfg.flip_mode[0] ? r_col : (r_col <= w_wm1) ? w_wm1 - r_col : '0;
    assign w_drow = !i_cfg.flip_mode[1] ? r_row : (r_row <= w_hm1) ? w_hm1 - r_row : '0;

    assign o_push            = w_accept && w_emit;
    assign o_job.pix         = i_pix;
    assign o_job.dest_column = w_dcol;
    assign o_job.dest_row    = w_drow;
    assign o_job.frame_end   = w_frame_last;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_phase = r_phase;
        if (w_accept) begin
            if (w_frame_last) begin
                n_col   = '0;
                n_row   = '0;
                n_phase = w_emit ? 8'd0 : r_phase + 8'd1;
            end else if (w_row_last) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
        end
    end

`ifndef SYNTH
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_frame_last |=> r_col == '0 && r_row == '0)
        else $error("position not cleared after frame end");
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_row_last |=> r_col == $past(r_col) + 1'b1 && $stable(r_row))
        else $error("column did not advance");
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_col) && $stable(r_row) && $stable(r_phase))
        else $error("counters moved without an item");
    a_push_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> w_accept && w_emit)
        else $error("push outside an emitted frame");
`endif

endmodule
`default_nettype wire

[design/rtgfd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtgfd_queue: short job queue
// Decouples position tracking from the gray arithmetic.
// ----------------------------------------------------------------------------
module rtgfd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rtgfd_pkg::t_job i_job,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output rtgfd_pkg::t_job      o_job
);
    import rtgfd_pkg::*;

    localparam int C_AW = $clog2(C_Q_DEPTH);
    localparam int C_CW = $clog2(C_Q_DEPTH + 1);

    t_job            r_mem [C_Q_DEPTH];
    logic [C_AW-1:0] r_wr, r_rd;
    logic [C_CW-1:0] r_count;
    logic            w_push, w_pop;

    assign o_full  = r_count == C_CW'(C_Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + C_CW'(w_push) - C_CW'(w_pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_CW'(C_Q_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        C_AW'(r_wr - r_rd) == C_AW'(r_count))
        else $error("pointers disagree with count");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("push lost");
`endif

endmodule
`default_nettype wire

[design/rtgfd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtgfd_back: gray arithmetic pipeline
// Weighted products in stage one; sum, then round and shift (luma) or shift and clamp (custom) into the output.
// ----------------------------------------------------------------------------
module rtgfd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rtgfd_pkg::t_cfg i_cfg,
    input  wire logic            i_q_valid,
    input  wire rtgfd_pkg::t_job i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output rtgfd_pkg::t_pix_out  o_pix
);
    import rtgfd_pkg::*;

    logic                       r_v1, r_v2;
    logic signed [26:0]         r_pb, r_pg, r_pr;
    logic [C_POS_W-1:0]         r_col1, r_row1;
    logic                       r_fe1;
    t_pix_out                   r_out;

    logic                       w_adv2, w_adv1;
    logic signed [C_COEF_W-1:0] w_kb, w_kg, w_kr;
    logic signed [26:0]         n_pb, n_pg, n_pr;
    logic signed [28:0]         w_sum, w_rnd;
    logic [15:0]                n_gray;

    assign w_adv2 = !r_v2 || !i_stall;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_pop  = i_q_valid && w_adv1;

    assign w_kb = i_cfg.custom_gray_enable ? i_cfg.coef_blue  : C_LUMA_B;
    assign w_kg = i_cfg.custom_gray_enable ? i_cfg.coef_green : C_LUMA_G;
    assign w_kr = i_cfg.custom_gray_enable ? i_cfg.coef_red   : C_LUMA_R;

    assign n_pb = $signed({1'b0, i_job.pix.blue})  * w_kb;
    assign n_pg = $signed({1'b0, i_job.pix.green}) * w_kg;
    assign n_pr = $signed({1'b0, i_job.pix.red})   * w_kr;

    assign w_sum = 29'(r_pb) + 29'(r_pg) + 29'(r_pr);
    assign w_rnd = w_sum + 29'sd8192;

    always_comb begin
        if (!i_cfg.custom_gray_enable) begin
            n_gray = {w_rnd[21:14], 8'h00};
        end else if (w_sum[28]) begin
            n_gray = 16'h0000;
        end else if (w_sum[27:24] != 4'd0) begin
            n_gray = 16'hFFFF;
        end else begin
            n_gray = w_sum[23:8];
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_pb   <= n_pb;
            r_pg   <= n_pg;
            r_pr   <= n_pr;
            r_col1 <= i_job.dest_column;
            r_row1 <= i_job.dest_row;
            r_fe1  <= i_job.frame_end;
        end
        if (w_adv2) begin
            r_out.gray_value  <= n_gray;
            r_out.dest_column <= r_col1;
            r_out.dest_row    <= r_row1;
            r_out.frame_end   <= r_fe1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_q_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign o_valid = r_v2;
    assign o_pix   = r_out;

`ifndef SYNTH
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && i_stall |=> r_v2 && $stable(r_out))
        else $error("stalled result changed");
    a_stage_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && w_adv2 |=> r_v2)
        else $error("stage one item lost");
    a_pop_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_v1)
        else $error("popped job not held");
`endif

endmodule
`default_nettype wire

[design/rgb_to_gray16_flip_decimate_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_gray16_flip_decimate_core: BGR pixel stream to 16-bit gray
// Converts raster pixels to gray with flip positions and frame decimation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall/i_pix carries one BGR pixel per item in
//   raster order. Output channel o_valid/i_stall/o_pix carries one gray item
//   with destination column, row and frame-end mark. Pixels of skipped frames
//   produce nothing.
//   Throughput is one pixel per cycle while o_stall is low, set by the counter
//   update in the front and the two-stage arithmetic pipeline in the back.
//   An accepted pixel passes the queue, the product stage and the output stage.
//   A four-entry queue separates the two parts; o_stall rises only when it
//   is full, so a stalled receiver holds its item while up to five more
//   pixels (one in the product stage, four in the queue) are still taken in.
//   Reset (synchronous, active low) restores the register defaults, clears
//   the position and frame counters and empties the queue and pipeline.
//   The user is to write registers through i_cfg_we/i_cfg_idx/i_cfg_data
//   only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rgb_to_gray16_flip_decimate_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire rtgfd_pkg::t_pix_in                 i_pix,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output rtgfd_pkg::t_pix_out                     o_pix,
    input  wire logic                               i_cfg_we,
    input  wire logic [2:0]                         i_cfg_idx,
    input  wire logic [rtgfd_pkg::C_CFG_DATA_W-1:0] i_cfg_data
);
    import rtgfd_pkg::*;

    t_cfg w_cfg;
    t_job w_push_job, w_head_job;
    logic w_push, w_full, w_q_valid, w_pop;

    rtgfd_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    rtgfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_pix    (i_pix),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    rtgfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_head_job)
    );

    rtgfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_pix     (o_pix)
    );

endmodule
`default_nettype wire

[sim/rgb_to_gray16_flip_decimate_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_gray16_flip_decimate_core_test: self-checking bench for the gray core
// Drives BGR pixel items through the core under several register settings,
// predicts gray value, flipped position, frame-end mark and frame decimation,
// and compares every output item against the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_to_gray16_flip_decimate_core_test;

    import rtgfd_pkg::*;

    localparam int CLK_HALF   = 2;
    localparam int RST_CYCLES = 5;
    localparam int LAT_WAIT   = 8;
    localparam int WD_LIMIT   = 2000;
    localparam int RAND_ITEMS = 750;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     pix_valid = 1'b0;
    logic     o_stall;
    t_pix_in  pix = '0;
    logic     o_valid;
    logic     recv_stall = 1'b0;
    t_pix_out o_pix;
    logic     cfg_we = 1'b0;
    t_reg_idx cfg_idx = REG_CUSTOM_GRAY;
    logic [C_CFG_DATA_W-1:0] cfg_data = '0;

    t_pix_in  pix_queue[$];
    t_pix_out gray_expected[$];
    t_pix_out pred_res;
    t_pix_out want_res;

    // predictor copy of registers and counters
    t_cfg        cfg_m;
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned phase_cnt;

    logic pix_taken = 1'b0;
    bit   hold_off = 1'b0;
    int   send_idle_pct = 37;
    int   recv_idle_pct = 76;
    int   quiet_cycles = 0;
    int   n_fail = 0;
    int   rand_issued = 0;

    rgb_to_gray16_flip_decimate_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (pix_valid),
        .o_stall    (o_stall),
        .i_pix      (pix),
        .o_valid    (o_valid),
        .i_stall    (recv_stall),
        .o_pix      (o_pix),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int unsigned size_limit(input logic [12:0] v, input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    // Advance the counters by one pixel; return 1 when the frame is emitted
    function automatic bit gray_predict(input t_pix_in p, output t_pix_out r);
        int unsigned w;
        int unsigned h;
        int unsigned cl;
        int unsigned rw;
        int unsigned lum;
        int          acc;
        bit          emit;
        bit          row_last;
        bit          frame_last;
        w = size_limit(cfg_m.frame_width, C_MAX_WIDTH);
        h = size_limit(cfg_m.frame_height, C_MAX_HEIGHT);
        emit = (phase_cnt + 1) >= cfg_m.frame_divider;
        row_last = col_cnt >= w - 1;
        frame_last = row_last && (row_cnt >= h - 1);
        cl = col_cnt;
        rw = row_cnt;
        if (cfg_m.flip_mode[0]) cl = (cl <= w - 1) ? (w - 1 - cl) : 0;
        if (cfg_m.flip_mode[1]) rw = (rw <= h - 1) ? (h - 1 - rw) : 0;

        if (cfg_m.custom_gray_enable) begin
            acc = int'($signed(cfg_m.coef_blue)) * int'(p.blue)
                + int'($signed(cfg_m.coef_green)) * int'(p.green)
                + int'($signed(cfg_m.coef_red)) * int'(p.red);
            if (acc < 0) r.gray_value = 16'h0000;
            else if ((acc >>> 8) > 65535) r.gray_value = 16'hFFFF;
            else r.gray_value = 16'(acc >>> 8);
        end else begin
            // Q14 luma, rounded by adding half an LSB
            lum = (int'(C_LUMA_B) * int'(p.blue) + int'(C_LUMA_G) * int'(p.green)
                + int'(C_LUMA_R) * int'(p.red) + 8192) >> 14;
            r.gray_value = {lum[7:0], 8'h00};
        end
        r.dest_column = cl[C_POS_W-1:0];
        r.dest_row    = rw[C_POS_W-1:0];
        r.frame_end   = frame_last;

        if (frame_last) begin
            col_cnt = 0;
            row_cnt = 0;
            phase_cnt = emit ? 0 : ((phase_cnt + 1) & 8'hFF);
        end else if (row_last) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1) & 12'hFFF;
        end else begin
            col_cnt = (col_cnt + 1) & 12'hFFF;
        end
        return emit;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    function automatic void push_pix(input logic [7:0] b, input logic [7:0] g,
                                     input logic [7:0] r);
        t_pix_in p;
        p.blue  = b;
        p.green = g;
        p.red   = r;
        pix_queue.insert(pix_queue.size(), p);
    endfunction

    function automatic logic [7:0] rand_chan();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 8'h00;
        if (k == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [C_COEF_W-1:0] rand_coef();
        int v;
        case ($urandom_range(3))
            0, 1: v = int'($urandom_range(22000)) - 2000;
            2: v = int'($urandom);
            default: begin
                case ($urandom_range(3))
                    0: v = 131071;
                    1: v = -131072;
                    2: v = 0;
                    default: v = 256;
                endcase
            end
        endcase
        return v[C_COEF_W-1:0];
    endfunction

    function automatic logic [12:0] frame_size(input bit big, input int max_small);
        if (!big) return 13'($urandom_range(max_small, 1));
        case ($urandom_range(3))
            0: return 13'd0;
            1: return 13'd4096;
            2: return 13'h1FFF;
            default: return 13'($urandom_range(8191, 4097));
        endcase
    endfunction

    // Write one register at a rising edge and mirror it in the predictor
    task automatic cfg_write(input t_reg_idx idx, input logic [C_CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_CUSTOM_GRAY: cfg_m.custom_gray_enable = val[0];
            REG_COEF_RED:    cfg_m.coef_red = val;
            REG_COEF_GREEN:  cfg_m.coef_green = val;
            REG_COEF_BLUE:   cfg_m.coef_blue = val;
            REG_FLIP_MODE:   cfg_m.flip_mode = val[1:0];
            REG_FRAME_W:     cfg_m.frame_width = val[12:0];
            REG_FRAME_H:     cfg_m.frame_height = val[12:0];
            REG_FRAME_DIV:   cfg_m.frame_divider = val[7:0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every item is in and every result is out, then let skipped
    // pixels clear the pipeline
    task automatic drain();
        do @(posedge clk);
        while (pix_queue.size() != 0 || pix_valid || gray_expected.size() != 0);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    task automatic run_phase(input int n_items, input bit pause);
        for (int i = 0; i < n_items; i++) push_pix(rand_chan(), rand_chan(), rand_chan());
        rand_issued += n_items;
        if (pause) begin
            while (pix_queue.size() > n_items / 2) @(posedge clk);
            hold_off = 1'b1;
            do @(posedge clk);
            while (pix_valid || gray_expected.size() != 0);
            hold_off = 1'b0;
        end
        drain();
    endtask

    // Sender: hold a stalled item, otherwise offer the next one or idle
    always @(negedge clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else if (!pix_valid || pix_taken) begin
            if (pix_queue.size() != 0 && !hold_off && $urandom_range(99) >= send_idle_pct) begin
                pix       <= pix_queue.pop_front();
                pix_valid <= 1'b1;
            end else begin
                pix_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        recv_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (pix_valid && !o_stall) begin
                if (gray_predict(pix, pred_res)) begin
                    gray_expected.insert(gray_expected.size(), pred_res);
                end
            end
            if (o_valid && !recv_stall) begin
                if (gray_expected.size() == 0) begin
                    $error("unexpected result: gray %0d col %0d row %0d end %0d",
                           o_pix.gray_value, o_pix.dest_column, o_pix.dest_row,
                           o_pix.frame_end);
                    n_fail++;
                end else begin
                    want_res = gray_expected.pop_front();
                    check_field("gray_value", want_res.gray_value, o_pix.gray_value);
                    check_field("dest_column", want_res.dest_column, o_pix.dest_column);
                    check_field("dest_row", want_res.dest_row, o_pix.dest_row);
                    check_field("frame_end", want_res.frame_end, o_pix.frame_end);
                end
            end
        end
        pix_taken <= rst_n && pix_valid && !o_stall;

        if ((pix_valid && !o_stall) || (o_valid && !recv_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("[rgb_to_gray16_flip_decimate_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        bit big;
        int n_items;
        int phase_no;

        cfg_m.custom_gray_enable = 1'b0;
        cfg_m.coef_red      = 18'sd256;
        cfg_m.coef_green    = 18'sd256;
        cfg_m.coef_blue     = 18'sd256;
        cfg_m.flip_mode     = 2'd0;
        cfg_m.frame_width   = 13'd640;
        cfg_m.frame_height  = 13'd480;
        cfg_m.frame_divider = 8'd1;
        col_cnt   = 0;
        row_cnt   = 0;
        phase_cnt = 0;

        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // standard luma at the reset settings
        push_pix(8'h00, 8'h00, 8'h00);
        push_pix(8'hFF, 8'hFF, 8'hFF);
        push_pix(8'h00, 8'h00, 8'hFF);
        push_pix(8'h00, 8'hFF, 8'h00);
        push_pix(8'hFF, 8'h00, 8'h00);
        drain();

        // extreme coefficients, zero sizes and a zero divider: 1x1 frames
        cfg_write(REG_CUSTOM_GRAY, 18'd1);
        cfg_write(REG_COEF_RED, 18'h1FFFF);
        cfg_write(REG_COEF_GREEN, 18'h20000);
        cfg_write(REG_COEF_BLUE, 18'd256);
        cfg_write(REG_FRAME_W, 18'd0);
        cfg_write(REG_FRAME_H, 18'd0);
        cfg_write(REG_FLIP_MODE, 18'd3);
        cfg_write(REG_FRAME_DIV, 18'd0);
        push_pix(8'h00, 8'h00, 8'hFF);
        push_pix(8'h00, 8'hFF, 8'h00);
        push_pix(8'hFF, 8'h00, 8'h00);
        push_pix(8'hFF, 8'hFF, 8'hFF);
        drain();

        // oversize frame saturates to the maximum; both flips map the first pixel to 4095
        cfg_write(REG_FRAME_W, 18'h1FFF);
        cfg_write(REG_FRAME_H, 18'h1FFF);
        push_pix(8'h10, 8'h20, 8'h30);
        push_pix(8'h40, 8'h50, 8'h60);
        push_pix(8'h70, 8'h80, 8'h90);
        drain();

        // shrink the frame while the column is already past the new end
        cfg_write(REG_FRAME_W, 18'd2);
        cfg_write(REG_FRAME_H, 18'd2);
        cfg_write(REG_FLIP_MODE, 18'd1);
        push_pix(8'h01, 8'h02, 8'h03);
        push_pix(8'hFE, 8'hFD, 8'hFC);
        drain();

        // decimation by three over single-pixel frames
        cfg_write(REG_CUSTOM_GRAY, 18'd0);
        cfg_write(REG_FRAME_W, 18'd1);
        cfg_write(REG_FRAME_H, 18'd1);
        cfg_write(REG_FLIP_MODE, 18'd0);
        cfg_write(REG_FRAME_DIV, 18'd3);
        for (int i = 0; i < 6; i++) push_pix(rand_chan(), rand_chan(), rand_chan());
        drain();

        // largest divider: one frame in 255 emitted
        cfg_write(REG_CUSTOM_GRAY, 18'($urandom_range(1)));
        cfg_write(REG_COEF_RED, rand_coef());
        cfg_write(REG_COEF_GREEN, rand_coef());
        cfg_write(REG_COEF_BLUE, rand_coef());
        cfg_write(REG_FRAME_DIV, 18'd255);
        run_phase(260, 1'b1);

        phase_no = 0;
        while (rand_issued < RAND_ITEMS) begin
            if (rand_issued < 250) begin
                send_idle_pct = 37;
                recv_idle_pct = 76;
            end else if (rand_issued < 500) begin
                send_idle_pct = 76;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            big = ($urandom_range(5) == 0);
            cfg_write(REG_CUSTOM_GRAY, 18'($urandom_range(1)));
            cfg_write(REG_COEF_RED, rand_coef());
            cfg_write(REG_COEF_GREEN, rand_coef());
            cfg_write(REG_COEF_BLUE, rand_coef());
            cfg_write(REG_FLIP_MODE, 18'($urandom_range(3)));
            cfg_write(REG_FRAME_W, 18'(frame_size(big, 12)));
            cfg_write(REG_FRAME_H, 18'(frame_size(big, 6)));
            cfg_write(REG_FRAME_DIV, 18'($urandom_range(3)));
            n_items = big ? $urandom_range(30, 8) : $urandom_range(60, 20);
            run_phase(n_items, (phase_no % 4) == 1);
            phase_no++;
        end

        drain();
        if (n_fail == 0 && gray_expected.size() == 0) begin
            $display("[rgb_to_gray16_flip_decimate_core] OK");
        end else begin
            $display("[rgb_to_gray16_flip_decimate_core] ERROR");
        end
        $finish;
    end

endmodule
